// ===== design/pwsc_pkg.sv =====
package pwsc_pkg;

  localparam int MAX_WIDTH_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int LEN_BITS       = 7;
  localparam int SCORE_BITS     = 22;
  localparam int MAX_SCORE_BITS = 22;
  localparam int HITS_BITS      = 32;
  localparam int CMD_BITS       = 2;
  localparam int CHAR_BITS      = 8;
  localparam int POS_BITS       = 6;
  localparam int ROW_BITS       = 2;
  localparam int VALUE_BITS     = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 22;

  localparam int SCORE_MAX = 2097151;
  localparam int SCORE_MIN = -2097152;

  localparam logic [CMD_BITS-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_BASE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_NEW  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SCORE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_SELECT = 2'd2;

  localparam logic [LEN_BITS-1:0]       WINDOW_LEN_RST = 7'd8;
  localparam logic [MAX_SCORE_BITS-1:0] MAX_SCORE_RST  = 22'd32768;

  localparam logic [CHAR_BITS-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_BITS-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_BITS-1:0] CHAR_T = 8'h54;
  localparam logic [CHAR_BITS-1:0] CHAR_N = 8'h4E;

  localparam logic [ROW_BITS-1:0] ROW_A = 2'd0;
  localparam logic [ROW_BITS-1:0] ROW_G = 2'd1;
  localparam logic [ROW_BITS-1:0] ROW_C = 2'd2;
  localparam logic [ROW_BITS-1:0] ROW_T = 2'd3;

  typedef struct packed {
    logic                ok;
    logic [ROW_BITS-1:0] code;
  } base_t;

  typedef struct packed {
    logic                shift;
    logic                code_ok;
    logic [ROW_BITS-1:0] code;
    logic [ROW_BITS-1:0] load_row;
  } cell_ctrl_t;

  function automatic base_t base_code(input logic [CHAR_BITS-1:0] ch);
    base_t b;
    b.ok   = 1'b1;
    b.code = ROW_A;
    unique case (ch)
      CHAR_A:  b.code = ROW_A;
      CHAR_G:  b.code = ROW_G;
      CHAR_C:  b.code = ROW_C;
      CHAR_T:  b.code = ROW_T;
      default: b.ok   = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// ===== design/pwsc_cell.sv =====
module pwsc_cell import pwsc_pkg::*; #(
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int PART_BITS   = WEIGHT_BITS_DEF + 6
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic                          load_en,
  input  logic signed [WEIGHT_BITS-1:0] load_value,
  input  logic signed [PART_BITS-1:0]   fwd_in,
  input  logic signed [PART_BITS-1:0]   rev_in,
  output logic signed [PART_BITS-1:0]   fwd_out,
  output logic signed [PART_BITS-1:0]   rev_out
);

  logic signed [WEIGHT_BITS-1:0] w_a_r, w_g_r, w_c_r, w_t_r;
  logic signed [WEIGHT_BITS-1:0] wf, wr;
  logic signed [PART_BITS-1:0]   add_f, add_r;
  logic signed [PART_BITS-1:0]   fwd_r, rev_r, fwd_nxt, rev_nxt;

  // reverse strand uses the complement row
  always_comb begin
    case (ctrl.code)
      ROW_A:   begin wf = w_a_r; wr = w_t_r; end
      ROW_G:   begin wf = w_g_r; wr = w_c_r; end
      ROW_C:   begin wf = w_c_r; wr = w_g_r; end
      default: begin wf = w_t_r; wr = w_a_r; end
    endcase
    add_f   = ctrl.code_ok ? PART_BITS'(wf) : '0;
    add_r   = ctrl.code_ok ? PART_BITS'(wr) : '0;
    fwd_nxt = fwd_in + add_f;
    rev_nxt = rev_in + add_r;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      case (ctrl.load_row)
        ROW_A:   w_a_r <= load_value;
        ROW_G:   w_g_r <= load_value;
        ROW_C:   w_c_r <= load_value;
        default: w_t_r <= load_value;
      endcase
    end
    if (ctrl.shift) begin
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
    end
  end

  assign fwd_out = fwd_r;
  assign rev_out = rev_r;

endmodule

// ===== design/pwsc_eval.sv =====
module pwsc_eval import pwsc_pkg::*; #(
  parameter int PART_BITS  = WEIGHT_BITS_DEF + 6,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         scored,
  input  logic signed [PART_BITS-1:0]  fwd_score,
  input  logic signed [PART_BITS-1:0]  rev_score,
  input  logic [MAX_SCORE_BITS-1:0]    max_score,
  input  logic                         count_select,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_window_scored,
  output logic                         out_hit,
  output logic signed [SCORE_BITS-1:0] out_best_score,
  output logic [HITS_BITS-1:0]         out_control_hits,
  output logic [HITS_BITS-1:0]         out_test_hits
);

  localparam int EW = (PART_BITS > SCORE_BITS) ? PART_BITS : SCORE_BITS;
  localparam logic signed [EW-1:0] SAT_HI = EW'(SCORE_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(SCORE_MIN);

  logic signed [PART_BITS-1:0]  mx;
  logic signed [EW-1:0]         mx_ext;
  logic signed [SCORE_BITS-1:0] best;
  logic signed [SCORE_BITS+2:0] best_ext, best5, max4;
  logic                         hit_c;

  logic                         out_valid_r;
  logic                         scored_r, hit_r;
  logic signed [SCORE_BITS-1:0] best_r;
  logic [COUNT_BITS-1:0]        control_cnt_r, control_cnt_nxt;
  logic [COUNT_BITS-1:0]        test_cnt_r, test_cnt_nxt;

  always_comb begin
    mx     = (rev_score > fwd_score) ? rev_score : fwd_score;
    mx_ext = EW'(mx);
    if (mx_ext > SAT_HI) begin
      best = SCORE_BITS'(SCORE_MAX);
    end else if (mx_ext < SAT_LO) begin
      best = SCORE_BITS'(SCORE_MIN);
    end else begin
      best = SCORE_BITS'(mx_ext);
    end
    best_ext = (SCORE_BITS+3)'(best);
    best5    = (best_ext <<< 2) + best_ext;
    max4     = $signed((SCORE_BITS+3)'({max_score, 2'b00}));
    hit_c    = scored && (best5 >= max4);

    control_cnt_nxt = control_cnt_r;
    test_cnt_nxt    = test_cnt_r;
    if (take && hit_c) begin
      if (!count_select && control_cnt_r != '1) begin
        control_cnt_nxt = control_cnt_r + 1'b1;
      end
      if (count_select && test_cnt_r != '1) begin
        test_cnt_nxt = test_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      control_cnt_r <= '0;
      test_cnt_r    <= '0;
    end else begin
      control_cnt_r <= control_cnt_nxt;
      test_cnt_r    <= test_cnt_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scored_r <= scored;
      hit_r    <= hit_c;
      best_r   <= scored ? best : '0;
    end
  end

  assign out_free          = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_window_scored = scored_r;
  assign out_hit           = hit_r;
  assign out_best_score    = best_r;
  assign out_control_hits  = HITS_BITS'(control_cnt_r);
  assign out_test_hits     = HITS_BITS'(test_cnt_r);

  a_unscored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !scored_r) |-> (!hit_r && best_r == '0))
    else $error("unscored result carries hit or score");

  a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(control_cnt_r) && $stable(test_cnt_r)))
    else $error("counter moved while result waits");

  a_control_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hit_c && !count_select && control_cnt_r != '1)
    |=> (control_cnt_r == $past(control_cnt_r) + 1'b1))
    else $error("control counter missed a hit");

endmodule

// ===== design/pwm_window_scan_counter.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | cmd, base_char, weight_pos/base/value
// out     | output    | out_valid / out_ready | window_scored, hit, best_score, hits
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
// One item per cycle sustained unless the output stalls; each result is registered in
// the chain stage, then the output register. Each cell updates its partial sums in the
// transfer cycle; the score select, saturation, hit test and counters act on take.
// Synchronous reset sets config defaults and clears run length, counters, valid flags.
// A stalled result holds one more item in the chain stage, then in_ready drops.
module pwm_window_scan_counter import pwsc_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CMD_BITS-1:0]          in_cmd,
  input  logic [CHAR_BITS-1:0]         in_base_char,
  input  logic [POS_BITS-1:0]          in_weight_pos,
  input  logic [ROW_BITS-1:0]          in_weight_base,
  input  logic signed [VALUE_BITS-1:0] in_weight_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_window_scored,
  output logic                         out_hit,
  output logic signed [SCORE_BITS-1:0] out_best_score,
  output logic [HITS_BITS-1:0]         out_control_hits,
  output logic [HITS_BITS-1:0]         out_test_hits,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int PART_BITS = WEIGHT_BITS + $clog2(MAX_WIDTH);
  localparam int IDXW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [LEN_BITS-1:0]       window_len_r;
  logic [MAX_SCORE_BITS-1:0] max_score_r;
  logic                      count_select_r;
  logic [LEN_BITS-1:0]       clean_run_r, clean_run_nxt, run_inc;
  logic                      s1_valid_r, s1_scored_r;

  logic                          in_xfer, cfg_xfer, is_n, is_base, scored, out_free, take;
  base_t                         bc;
  logic [LEN_BITS-1:0]           eff_len;
  logic [IDXW-1:0]               klast;
  logic signed [WEIGHT_BITS-1:0] load_value;
  cell_ctrl_t                    ctrl;

  logic signed [PART_BITS-1:0] fwd_in  [MAX_WIDTH];
  logic signed [PART_BITS-1:0] rev_in  [MAX_WIDTH];
  logic signed [PART_BITS-1:0] fwd_out [MAX_WIDTH];
  logic signed [PART_BITS-1:0] rev_out [MAX_WIDTH];

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_xfer   = in_valid && in_ready;
  assign take      = s1_valid_r && out_free;

  assign bc         = base_code(in_base_char);
  assign is_n       = (in_base_char == CHAR_N);
  assign is_base    = (in_cmd == CMD_BASE);
  assign load_value = WEIGHT_BITS'(in_weight_value);

  always_comb begin
    if (window_len_r == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (window_len_r > LEN_BITS'(MAX_WIDTH)) begin
      eff_len = LEN_BITS'(MAX_WIDTH);
    end else begin
      eff_len = window_len_r;
    end
    klast = IDXW'(eff_len - 1'b1);

    run_inc = (clean_run_r < LEN_BITS'(MAX_WIDTH)) ? clean_run_r + 1'b1 : clean_run_r;
    scored  = in_xfer && is_base && !is_n && (run_inc >= eff_len);

    clean_run_nxt = clean_run_r;
    if (cfg_xfer && cfg_index == CFG_WINDOW_LEN) begin
      clean_run_nxt = '0;
    end else if (in_xfer) begin
      unique case (in_cmd)
        CMD_BASE: clean_run_nxt = is_n ? '0 : run_inc;
        CMD_NEW:  clean_run_nxt = '0;
        default:  clean_run_nxt = clean_run_r;
      endcase
    end

    ctrl.shift    = in_xfer && is_base && !is_n;
    ctrl.code_ok  = bc.ok;
    ctrl.code     = bc.code;
    ctrl.load_row = in_weight_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r   <= WINDOW_LEN_RST;
      max_score_r    <= MAX_SCORE_RST;
      count_select_r <= 1'b0;
      clean_run_r    <= '0;
      s1_valid_r     <= 1'b0;
      s1_scored_r    <= 1'b0;
    end else begin
      clean_run_r <= clean_run_nxt;
      if (cfg_xfer) begin
        unique case (cfg_index)
          CFG_WINDOW_LEN:   window_len_r   <= cfg_data[LEN_BITS-1:0];
          CFG_MAX_SCORE:    max_score_r    <= cfg_data[MAX_SCORE_BITS-1:0];
          CFG_COUNT_SELECT: count_select_r <= cfg_data[0];
          default:          ;
        endcase
      end
      if (in_xfer) begin
        s1_valid_r  <= 1'b1;
        s1_scored_r <= scored;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // forward sums run up the chain, reverse sums run down from the window's last cell
  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign fwd_in[j] = '0;
    end else begin : g_fwd
      assign fwd_in[j] = fwd_out[j-1];
    end
    if (j == MAX_WIDTH - 1) begin : g_tail
      assign rev_in[j] = '0;
    end else begin : g_rev
      assign rev_in[j] = (klast == IDXW'(j)) ? '0 : rev_out[j+1];
    end

    pwsc_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .PART_BITS   (PART_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .load_en    (in_xfer && in_cmd == CMD_LOAD &&
                   {1'b0, in_weight_pos} == LEN_BITS'(j)),
      .load_value (load_value),
      .fwd_in     (fwd_in[j]),
      .rev_in     (rev_in[j]),
      .fwd_out    (fwd_out[j]),
      .rev_out    (rev_out[j])
    );
  end

  pwsc_eval #(
    .PART_BITS  (PART_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .clk               (clk),
    .rst_n             (rst_n),
    .take              (take),
    .scored            (s1_scored_r),
    .fwd_score         (fwd_out[klast]),
    .rev_score         (rev_out[0]),
    .max_score         (max_score_r),
    .count_select      (count_select_r),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_window_scored (out_window_scored),
    .out_hit           (out_hit),
    .out_best_score    (out_best_score),
    .out_control_hits  (out_control_hits),
    .out_test_hits     (out_test_hits)
  );

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |-> !in_ready)
    else $error("input taken while chain stage is stuck");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    clean_run_r <= LEN_BITS'(MAX_WIDTH))
    else $error("clean run beyond chain length");

  a_nonbase_unscored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (!is_base || is_n)) |=> !s1_scored_r)
    else $error("window scored without a base");

endmodule

// ===== sim/pwm_window_scan_counter_tb.sv =====
`timescale 1ns / 1ps

module pwm_window_scan_counter_tb import pwsc_pkg::*;;

  localparam logic [CMD_BITS-1:0]     CMD_NOP   = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    logic [CMD_BITS-1:0]          cmd;
    logic [CHAR_BITS-1:0]         ch;
    logic [POS_BITS-1:0]          pos;
    logic [ROW_BITS-1:0]          row;
    logic signed [VALUE_BITS-1:0] value;
  } scan_item_t;

  typedef struct {
    logic                         scored;
    logic                         hit;
    logic signed [SCORE_BITS-1:0] score;
    logic [HITS_BITS-1:0]         ctrl;
    logic [HITS_BITS-1:0]         test;
  } scan_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [CMD_BITS-1:0]          in_cmd = '0;
  logic [CHAR_BITS-1:0]         in_base_char = '0;
  logic [POS_BITS-1:0]          in_weight_pos = '0;
  logic [ROW_BITS-1:0]          in_weight_base = '0;
  logic signed [VALUE_BITS-1:0] in_weight_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_window_scored;
  logic                         out_hit;
  logic signed [SCORE_BITS-1:0] out_best_score;
  logic [HITS_BITS-1:0]         out_control_hits;
  logic [HITS_BITS-1:0]         out_test_hits;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

  pwm_window_scan_counter DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // score chain state
  logic signed [VALUE_BITS-1:0] weights [256];
  longint                       fwd_sum [MAX_WIDTH_DEF];
  longint                       rev_sum [MAX_WIDTH_DEF];
  int                           clean_len;
  logic [HITS_BITS-1:0]         ctrl_count;
  logic [HITS_BITS-1:0]         test_count;
  logic [LEN_BITS-1:0]          len_reg;
  logic [MAX_SCORE_BITS-1:0]    max_reg;
  logic                         sel_reg;

  scan_item_t   pending_items [$];
  scan_result_t expected [$];
  bit           loaded [256];
  int           gen_len;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           mismatches = 0;
  int           cycles = 0;
  logic [CHAR_BITS-1:0] acgt [4] = '{CHAR_A, CHAR_G, CHAR_C, CHAR_T};
  scan_item_t   next_item;
  scan_item_t   seen_item;
  scan_result_t exp_r;

  function automatic int eff_len(input logic [LEN_BITS-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return len;
  endfunction

  function automatic int base_row(input logic [CHAR_BITS-1:0] ch);
    case (ch)
      CHAR_A:  return ROW_A;
      CHAR_G:  return ROW_G;
      CHAR_C:  return ROW_C;
      CHAR_T:  return ROW_T;
      default: return -1;
    endcase
  endfunction

  function void clear_chain();
    foreach (fwd_sum[i]) begin
      fwd_sum[i] = 0;
      rev_sum[i] = 0;
    end
    clean_len = 0;
  endfunction

  function void apply_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                          input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_WINDOW_LEN: begin
        len_reg = data[LEN_BITS-1:0];
        clean_len = 0;
      end
      CFG_MAX_SCORE:    max_reg = data;
      CFG_COUNT_SELECT: sel_reg = data[0];
      default: ;
    endcase
  endfunction

  function automatic scan_result_t scan_step(input scan_item_t it);
    scan_result_t r;
    int           k;
    int           code;
    int           j;
    longint       fw;
    longint       rw;
    longint       best;
    longint       lim;
    r.scored = 1'b0;
    r.hit    = 1'b0;
    r.score  = '0;
    case (it.cmd)
      CMD_LOAD: weights[{it.pos, it.row}] = it.value;
      CMD_NEW:  clear_chain();
      CMD_BASE: begin
        if (it.ch == CHAR_N) begin
          clean_len = 0;
        end else begin
          k = eff_len(len_reg);
          code = base_row(it.ch);
          for (j = k - 1; j > 0; j--) begin
            fw = 0;
            rw = 0;
            if (code >= 0) begin
              fw = weights[j * 4 + code];
              rw = weights[(k - 1 - j) * 4 + 3 - code];
            end
            fwd_sum[j] = fwd_sum[j-1] + fw;
            rev_sum[j] = rev_sum[j-1] + rw;
          end
          if (code >= 0) begin
            fwd_sum[0] = weights[code];
            rev_sum[0] = weights[(k - 1) * 4 + 3 - code];
          end else begin
            fwd_sum[0] = 0;
            rev_sum[0] = 0;
          end
          if (clean_len < MAX_WIDTH_DEF) clean_len++;
          if (clean_len >= k) begin
            best = (rev_sum[k-1] > fwd_sum[k-1]) ? rev_sum[k-1] : fwd_sum[k-1];
            if (best > SCORE_MAX) best = SCORE_MAX;
            if (best < SCORE_MIN) best = SCORE_MIN;
            lim = max_reg;
            r.scored = 1'b1;
            r.score  = best[SCORE_BITS-1:0];
            if (5 * best >= 4 * lim) begin
              r.hit = 1'b1;
              if (!sel_reg) begin
                if (ctrl_count != '1) ctrl_count++;
              end else begin
                if (test_count != '1) test_count++;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.ctrl = ctrl_count;
    r.test = test_count;
    return r;
  endfunction

  // stimulus generation
  function automatic logic signed [VALUE_BITS-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function void queue_item(input logic [CMD_BITS-1:0] cmd, input logic [CHAR_BITS-1:0] ch,
                           input logic [POS_BITS-1:0] pos, input logic [ROW_BITS-1:0] row,
                           input logic signed [VALUE_BITS-1:0] value);
    scan_item_t it;
    it.cmd   = cmd;
    it.ch    = ch;
    it.pos   = pos;
    it.row   = row;
    it.value = value;
    pending_items.push_back(it);
    if (cmd == CMD_LOAD) loaded[{pos, row}] = 1'b1;
  endfunction

  // a scored base reads its own row and the complement row at every window position
  function void queue_base(input logic [CHAR_BITS-1:0] ch);
    int code;
    int p;
    code = base_row(ch);
    if (code >= 0) begin
      for (p = 0; p < gen_len; p++) begin
        if (!loaded[p * 4 + code])
          queue_item(CMD_LOAD, CHAR_BITS'($urandom), POS_BITS'(p), ROW_BITS'(code),
                     rand_weight());
        if (!loaded[p * 4 + 3 - code])
          queue_item(CMD_LOAD, CHAR_BITS'($urandom), POS_BITS'(p), ROW_BITS'(3 - code),
                     rand_weight());
      end
    end
    queue_item(CMD_BASE, ch, POS_BITS'($urandom), ROW_BITS'($urandom),
               VALUE_BITS'($urandom));
  endfunction

  function void fill_random(input int count);
    int                   r;
    int                   brk;
    logic [CHAR_BITS-1:0] ch;
    brk = (gen_len > 16) ? 8 : 80;
    repeat (count) begin
      r = $urandom_range(999);
      if (r < brk) begin
        if (r[0]) queue_base(CHAR_N);
        else queue_item(CMD_NEW, CHAR_BITS'($urandom), POS_BITS'($urandom),
                        ROW_BITS'($urandom), VALUE_BITS'($urandom));
      end else if (r < 700) begin
        queue_base(acgt[$urandom_range(3)]);
      end else if (r < 790) begin
        do ch = CHAR_BITS'($urandom);
        while (ch == CHAR_A || ch == CHAR_G || ch == CHAR_C || ch == CHAR_T || ch == CHAR_N);
        queue_base(ch);
      end else if (r < 970) begin
        if ($urandom_range(3) != 0)
          queue_item(CMD_LOAD, CHAR_BITS'($urandom), POS_BITS'($urandom_range(gen_len - 1)),
                     ROW_BITS'($urandom), rand_weight());
        else
          queue_item(CMD_LOAD, CHAR_BITS'($urandom), POS_BITS'($urandom),
                     ROW_BITS'($urandom), rand_weight());
      end else begin
        queue_item(CMD_NOP, CHAR_BITS'($urandom), POS_BITS'($urandom),
                   ROW_BITS'($urandom), VALUE_BITS'($urandom));
      end
    end
  endfunction

  task wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task set_phase(input logic [CFG_DATA_BITS-1:0] wl, input logic [CFG_DATA_BITS-1:0] ms,
                 input logic [CFG_DATA_BITS-1:0] cs, input int send_pct, input int recv_pct);
    wait_idle();
    cfg_write(CFG_WINDOW_LEN, wl);
    cfg_write(CFG_MAX_SCORE, ms);
    cfg_write(CFG_COUNT_SELECT, cs);
    gen_len = eff_len(wl[LEN_BITS-1:0]);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid        <= 1'b1;
        in_cmd          <= next_item.cmd;
        in_base_char    <= next_item.ch;
        in_weight_pos   <= next_item.pos;
        in_weight_base  <= next_item.row;
        in_weight_value <= next_item.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor: check result transfers, then predict for input transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          $error("result with nothing expected: best_score %0d", out_best_score);
          mismatches++;
        end else begin
          exp_r = expected.pop_front();
          if (out_window_scored !== exp_r.scored) begin
            $error("window_scored: expected %0d, got %0d", exp_r.scored, out_window_scored);
            mismatches++;
          end
          if (out_hit !== exp_r.hit) begin
            $error("hit: expected %0d, got %0d", exp_r.hit, out_hit);
            mismatches++;
          end
          if (out_best_score !== exp_r.score) begin
            $error("best_score: expected %0d, got %0d", exp_r.score, out_best_score);
            mismatches++;
          end
          if (out_control_hits !== exp_r.ctrl) begin
            $error("control_hits: expected %0d, got %0d", exp_r.ctrl, out_control_hits);
            mismatches++;
          end
          if (out_test_hits !== exp_r.test) begin
            $error("test_hits: expected %0d, got %0d", exp_r.test, out_test_hits);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        seen_item.cmd   = in_cmd;
        seen_item.ch    = in_base_char;
        seen_item.pos   = in_weight_pos;
        seen_item.row   = in_weight_base;
        seen_item.value = in_weight_value;
        expected.push_back(scan_step(seen_item));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[pwm_window_scan_counter] ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] rnd_len;
    logic [CFG_DATA_BITS-1:0] rnd_max;
    logic [CFG_DATA_BITS-1:0] rnd_sel;
    foreach (weights[i]) begin
      weights[i] = '0;
      loaded[i] = 1'b0;
    end
    clear_chain();
    ctrl_count = '0;
    test_count = '0;
    len_reg = WINDOW_LEN_RST;
    max_reg = MAX_SCORE_RST;
    sel_reg = 1'b0;
    gen_len = eff_len(WINDOW_LEN_RST);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero window length acts as one
    set_phase(22'd0, 22'd1, 22'd0, 0, 0);
    queue_item(CMD_LOAD, 8'h00, 6'd0, ROW_A, 16'sh7FFF);
    queue_item(CMD_LOAD, 8'hFF, 6'd0, ROW_T, 16'sh8000);
    queue_item(CMD_LOAD, CHAR_BITS'($urandom), 6'd0, ROW_G, 16'sh0000);
    queue_item(CMD_LOAD, CHAR_BITS'($urandom), 6'd0, ROW_C, 16'sh1000);
    queue_item(CMD_LOAD, CHAR_BITS'($urandom), 6'd63, ROW_G, rand_weight());
    queue_base(CHAR_A);
    queue_base(CHAR_T);
    queue_base(CHAR_G);
    queue_base(CHAR_C);
    queue_base(CHAR_N);
    queue_base(8'h78);
    queue_base(8'h00);
    queue_base(8'hFF);
    queue_base(CHAR_A);
    queue_item(CMD_NEW, CHAR_BITS'($urandom), POS_BITS'($urandom), ROW_BITS'($urandom),
               VALUE_BITS'($urandom));
    queue_item(CMD_NOP, CHAR_BITS'($urandom), POS_BITS'($urandom), ROW_BITS'($urandom),
               VALUE_BITS'($urandom));
    queue_base(8'h61);
    queue_base(CHAR_G);

    set_phase(22'd4, 22'd20000, 22'd1, 0, 0);
    fill_random(50);
    set_phase(22'd64, 22'h3FFFFF, 22'd0, 88, 0);
    fill_random(100);
    // above the maximum acts as the maximum; zero max_score makes every score >= 0 a hit
    set_phase(22'd127, 22'd0, 22'd1, 0, 88);
    fill_random(80);
    set_phase(22'd1, 22'd1, 22'd0, 26, 26);
    fill_random(40);
    rnd_len = CFG_DATA_BITS'(($urandom & 32'h003F_FF80) | $urandom_range(20, 2));
    rnd_max = CFG_DATA_BITS'($urandom_range(60000, 1));
    rnd_sel = CFG_DATA_BITS'(($urandom & 32'h003F_FFFE) | $urandom_range(1));
    set_phase(rnd_len, rnd_max, rnd_sel, 0, 0);
    cfg_write(CFG_SPARE, CFG_DATA_BITS'($urandom));
    fill_random(40);
    set_phase(22'd12, 22'd40000, 22'd0, 26, 26);
    fill_random(30);

    wait_idle();
    if (mismatches == 0) begin
      $display("[pwm_window_scan_counter] OK");
    end else begin
      $display("[pwm_window_scan_counter] ERROR");
    end
    $finish;
  end

endmodule

// ===== pwm_window_scan_counter.f =====
design/pwsc_pkg.sv
design/pwsc_cell.sv
design/pwsc_eval.sv
design/pwm_window_scan_counter.sv
sim/pwm_window_scan_counter_tb.sv
